// File: hdl/dtt_pkg.sv
package dtt_pkg;

    localparam int ELAPSED_W = 16;
    localparam int ACCUM_W   = 32;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_VALUE = 2'd2;

    localparam logic [1:0] SEL_4096   = 2'd0;
    localparam logic [1:0] SEL_262144 = 2'd1;
    localparam logic [1:0] SEL_65536  = 2'd2;
    localparam logic [1:0] SEL_16384  = 2'd3;

    localparam logic [ACCUM_W-1:0] DIV_PERIOD_NS = ACCUM_W'(1000000000 / 16384);
    localparam logic [ACCUM_W-1:0] ACCUM_MAX     = {ACCUM_W{1'b1}};

    typedef struct packed {
        logic                 timer_enable;
        logic [1:0]           clock_select;
        logic [COUNT_W-1:0]   reload_value;
    } cfg_t;

    typedef struct packed {
        logic [ACCUM_W-1:0] tima_accum;
        logic [ACCUM_W-1:0] div_accum;
        logic [COUNT_W-1:0] tima_count;
        logic [COUNT_W-1:0] div_count;
    } state_t;

    function automatic logic [ACCUM_W-1:0] tima_period(input logic [1:0] sel);
        logic [ACCUM_W-1:0] p;
        unique case (sel)
            SEL_4096:   p = ACCUM_W'(1000000000 / 4096);
            SEL_262144: p = ACCUM_W'(1000000000 / 262144);
            SEL_65536:  p = ACCUM_W'(1000000000 / 65536);
            SEL_16384:  p = ACCUM_W'(1000000000 / 16384);
            default:    p = ACCUM_W'(1000000000 / 4096);
        endcase
        return p;
    endfunction

    function automatic logic [ACCUM_W-1:0] sat_add(input logic [ACCUM_W-1:0] acc,
                                                   input logic [ELAPSED_W-1:0] add);
        logic [ACCUM_W:0] sum;
        sum = {1'b0, acc} + {{(ACCUM_W + 1 - ELAPSED_W){1'b0}}, add};
        return sum[ACCUM_W] ? ACCUM_MAX : sum[ACCUM_W-1:0];
    endfunction

endpackage

// File: hdl/dtt_step.sv
module dtt_step
    import dtt_pkg::*;
(
    input  cfg_t                 cfg,
    input  state_t               state,
    input  logic [ELAPSED_W-1:0] elapsed_ns,
    output state_t               state_next,
    output logic                 timer_irq
);

    logic [ACCUM_W-1:0] tima_sum;
    logic [ACCUM_W-1:0] div_sum;
    logic [COUNT_W-1:0] tima_inc;
    logic               tima_hit;
    logic               div_hit;

    assign tima_sum = sat_add(state.tima_accum, elapsed_ns);
    assign div_sum  = sat_add(state.div_accum, elapsed_ns);
    assign tima_hit = cfg.timer_enable && (tima_sum >= tima_period(cfg.clock_select));
    assign div_hit  = div_sum >= DIV_PERIOD_NS;
    assign tima_inc = state.tima_count + COUNT_W'(1);

    always_comb
    begin
        state_next = state;
        timer_irq  = 1'b0;
        state_next.tima_accum = tima_sum;
        state_next.div_accum  = div_sum;
        if (tima_hit)
        begin
            state_next.tima_accum = '0;
            if (tima_inc == '0)
            begin
                state_next.tima_count = cfg.reload_value;
                timer_irq = 1'b1;
            end
            else
            begin
                state_next.tima_count = tima_inc;
            end
        end
        if (div_hit)
        begin
            state_next.div_accum = '0;
            state_next.div_count = state.div_count + COUNT_W'(1);
        end
    end

endmodule

// File: hdl/div_tima_timer.sv
// channel | dir | tdata (low bit up)                  | tuser
// s_*     | in  | elapsed_ns[15:0]                    | -
// m_*     | out | tima_value[7:0], div_value[15:8]    | timer_irq[0]
// cfg_*   | in  | write: cfg_index, cfg_data          | -
// One request per cycle sustained while m_tready is high; m_tvalid is registered.
// The request sits in an input register, the timer state and result update as
// it moves into the output register, so s_tready stays high while one result
// waits. Reset (rst_n low, asynchronous) clears state, config and valids.
// s_tready drops only with both the input and the output register full.
module div_tima_timer
    import dtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // elapsed_ns[15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // tima_value[7:0], div_value[15:8]
    output logic                  m_tuser,   // timer_irq[0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg_reg;
    state_t               state_reg;
    state_t               state_next;
    logic                 in_valid_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   tima_out_reg;
    logic [COUNT_W-1:0]   div_out_reg;
    logic                 irq_out_reg;
    logic                 irq_next;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dtt_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .elapsed_ns (elapsed_reg),
        .state_next (state_next),
        .timer_irq  (irq_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMER_ENABLE: cfg_reg.timer_enable <= cfg_data[0];
                CFG_CLOCK_SELECT: cfg_reg.clock_select <= cfg_data[1:0];
                CFG_RELOAD_VALUE: cfg_reg.reload_value <= cfg_data[COUNT_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            elapsed_reg <= s_tdata[ELAPSED_W-1:0];
        end
        if (advance)
        begin
            tima_out_reg <= state_next.tima_count;
            div_out_reg  <= state_next.div_count;
            irq_out_reg  <= irq_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {div_out_reg, tima_out_reg};
    assign m_tuser  = irq_out_reg;

endmodule

// File: hdl/dtt_checker.sv
module dtt_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [15:0]           s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [15:0]           m_tdata,
    input logic                  m_tuser
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
        else $error("request changed while stalled");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with output free");

    a_request_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("accepted request did not reach output");

endmodule

bind div_tima_timer dtt_checker u_dtt_checker (.*);

// File: test/tb_top.sv
module tb_top;
    import dtt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 100000;
    localparam int LONG_IDLE_ITEMS = 40;
    localparam logic [ACCUM_W-1:0] TIMA_PERIOD_NS [4] = '{
        ACCUM_W'(244140), ACCUM_W'(3814), ACCUM_W'(15258), ACCUM_W'(61035)
    };

    typedef struct packed {
        logic [COUNT_W-1:0] tima;
        logic [COUNT_W-1:0] div;
        logic               irq;
    } timer_reading_t;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [ELAPSED_W-1:0]  ns;
        logic                  typed;
        timer_reading_t        reading;
    } timer_row_t;

    localparam timer_row_t SCRIPT [23] = '{
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd0,     1'b1, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b1, '{8'd0, 8'd1, 1'b0}},
        '{ROW_WRITE, CFG_UNUSED,       8'hFF, 16'd0,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_WRITE, CFG_TIMER_ENABLE, 8'hFE, 16'd0,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b1, '{8'd0, 8'd2, 1'b0}},
        '{ROW_WRITE, CFG_TIMER_ENABLE, 8'h01, 16'd0,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_WRITE, CFG_CLOCK_SELECT, 8'hFD, 16'd0,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_WRITE, CFG_RELOAD_VALUE, 8'hFF, 16'd0,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd0,     1'b1, '{8'd1, 8'd2, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd3813,  1'b1, '{8'd1, 8'd2, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd1,     1'b1, '{8'd2, 8'd2, 1'b0}},
        '{ROW_WRITE, CFG_CLOCK_SELECT, {6'd0, SEL_65536}, 16'd0, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd15257, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd1,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_WRITE, CFG_CLOCK_SELECT, {6'd0, SEL_16384}, 16'd0, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd61035, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_WRITE, CFG_CLOCK_SELECT, {6'd0, SEL_4096}, 16'd0, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_WRITE, CFG_RELOAD_VALUE, 8'h00, 16'd0,     1'b0, '{8'd0, 8'd0, 1'b0}},
        '{ROW_TICK,  CFG_TIMER_ENABLE, 8'h00, 16'd65535, 1'b0, '{8'd0, 8'd0, 1'b0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  timer_on;
    logic [1:0]            period_sel;
    logic [COUNT_W-1:0]    reload_count;
    logic [ACCUM_W-1:0]    tima_acc;
    logic [ACCUM_W-1:0]    div_acc;
    logic [COUNT_W-1:0]    tima_cnt;
    logic [COUNT_W-1:0]    div_cnt;

    timer_reading_t readings_due [$];
    int             fails = 0;
    int             cycle_count = 0;
    int             idle_max = 3;
    int             sink_wait = 0;

    div_tima_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ACCUM_W-1:0] add_clamped(input logic [ACCUM_W-1:0] acc,
                                                       input logic [ELAPSED_W-1:0] ns);
        logic [ACCUM_W:0] sum;
        sum = {1'b0, acc} + (ACCUM_W + 1)'(ns);
        return sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
    endfunction

    function automatic timer_reading_t advance_timer(input logic [ELAPSED_W-1:0] ns);
        timer_reading_t r;
        r.irq = 1'b0;
        tima_acc = add_clamped(tima_acc, ns);
        div_acc = add_clamped(div_acc, ns);
        if (timer_on && tima_acc >= TIMA_PERIOD_NS[period_sel])
        begin
            tima_cnt = tima_cnt + COUNT_W'(1);
            if (tima_cnt == '0)
            begin
                tima_cnt = reload_count;
                r.irq = 1'b1;
            end
            tima_acc = '0;
        end
        if (div_acc >= DIV_PERIOD_NS)
        begin
            div_cnt = div_cnt + COUNT_W'(1);
            div_acc = '0;
        end
        r.tima = tima_cnt;
        r.div = div_cnt;
        return r;
    endfunction

    // hold the write until every outstanding request has drained
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_TIMER_ENABLE: timer_on = data[0];
            CFG_CLOCK_SELECT: period_sel = data[1:0];
            CFG_RELOAD_VALUE: reload_count = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_elapsed(input logic [ELAPSED_W-1:0] ns, input logic typed,
                                input timer_reading_t fixed);
        int gap;
        timer_reading_t r;
        gap = $urandom_range(0, idle_max);
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ns;
        do
            @(posedge clk);
        while (!s_tready);
        r = advance_timer(ns);
        readings_due.push_back(typed ? fixed : r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int draw;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end
        else if (sink_wait > 0)
        begin
            sink_wait <= sink_wait - 1;
            m_tready <= (sink_wait == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            draw = $urandom_range(0, idle_max);
            sink_wait <= draw;
            m_tready <= (draw == 0);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        timer_reading_t due;
        cycle_count <= cycle_count + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (readings_due.size() == 0)
            begin
                $error("result with nothing pending: tdata=%h tuser=%b", m_tdata, m_tuser);
                fails++;
            end
            else
            begin
                due = readings_due.pop_front();
                if (m_tdata[7:0] !== due.tima)
                begin
                    $error("tima_value: expected %0d, got %0d", due.tima, m_tdata[7:0]);
                    fails++;
                end
                if (m_tdata[15:8] !== due.div)
                begin
                    $error("div_value: expected %0d, got %0d", due.div, m_tdata[15:8]);
                    fails++;
                end
                if (m_tuser !== due.irq)
                begin
                    $error("timer_irq: expected %0b, got %0b", due.irq, m_tuser);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("[div_tima_timer] ERROR");
        $finish;
    end

    initial
    begin
        logic [ELAPSED_W-1:0] ns;
        timer_on = 1'b0;
        period_sel = '0;
        reload_count = '0;
        tima_acc = '0;
        div_acc = '0;
        tima_cnt = '0;
        div_cnt = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[k])
        begin
            if (SCRIPT[k].kind == ROW_WRITE)
                write_register(SCRIPT[k].idx, SCRIPT[k].data);
            else
                push_elapsed(SCRIPT[k].ns, SCRIPT[k].typed, SCRIPT[k].reading);
        end

        // grow the TIMA accumulator far past every period with counting off
        idle_max = 0;
        write_register(CFG_TIMER_ENABLE, 8'h00);
        repeat (LONG_IDLE_ITEMS) push_elapsed(16'hFFFF, 1'b0, '0);
        write_register(CFG_TIMER_ENABLE, 8'h01);
        push_elapsed(16'd0, 1'b0, '0);

        for (int p = 0; p < 8; p++)
        begin
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            write_register(CFG_TIMER_ENABLE, {7'($urandom), 1'(p != 6)});
            write_register(CFG_CLOCK_SELECT, {6'($urandom), 2'(p)});
            write_register(CFG_RELOAD_VALUE,
                           (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
            if ($urandom_range(0, 1) == 1)
                write_register(CFG_UNUSED, 8'($urandom));
            repeat (250)
            begin
                case ($urandom_range(0, 7))
                    0: ns = '0;
                    1: ns = '1;
                    2: ns = 16'($urandom_range(3800, 3830));
                    3: ns = 16'($urandom_range(61000, 61100));
                    default: ns = 16'($urandom);
                endcase
                push_elapsed(ns, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("[div_tima_timer] OK");
        else
            $display("[div_tima_timer] ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/dtt_pkg.sv
hdl/dtt_step.sv
hdl/div_tima_timer.sv
hdl/dtt_checker.sv
test/tb_top.sv
